// ===== design/bdd_pkg.sv =====
`default_nettype none

package bdd_pkg;

	// store geometry
	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int SUM_W  = IDX_W + 1;

	// beat field widths
	localparam int ACT_W   = 3;
	localparam int VAL_W   = 32;
	localparam int COUNT_W = 5;

	// action codes
	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_BACK   = 3'd2,
		ACT_POP_FRONT  = 3'd3,
		ACT_DUMP       = 3'd4
	} act_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic exec;
		logic dump_start;
		logic rd_en;
		logic emit;
		logic busy;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_dump;
		logic empty;
		logic walk_last;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== design/bdd_in_if.sv =====
`default_nettype none

interface bdd_in_if import bdd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [VAL_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

// ===== design/bdd_out_if.sv =====
`default_nettype none

interface bdd_out_if import bdd_pkg::*; ();
	logic               valid;
	logic               ready;
	status_t            status;
	logic [VAL_W-1:0]   element;
	logic               last;
	logic [COUNT_W-1:0] count;

	modport source (output valid, output status, output element, output last,
		output count, input ready);
	modport sink (input valid, input status, input element, input last,
		input count, output ready);
endinterface

`default_nettype wire

// ===== design/bdd_ctrl.sv =====
`default_nettype none

module bdd_ctrl import bdd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire dp_stat_t stat,
	output ctl_cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = stat.out_free;
				if (in_valid && stat.out_free) begin
					if (stat.req_dump && !stat.empty) begin
						cmd.dump_start = 1'b1;
						state_d        = S_READ;
					end else begin
						cmd.exec = 1'b1;
					end
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = stat.walk_last ? S_IDLE : S_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		cmd.busy = (state_q != S_IDLE);
	end

endmodule

`default_nettype wire

// ===== design/bdd_dpath.sv =====
`default_nettype none

module bdd_dpath import bdd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [ACT_W-1:0]   in_action,
	input  wire logic [VAL_W-1:0]   in_value,
	input  wire ctl_cmd_t           cmd,
	output dp_stat_t                stat,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output status_t                 out_status,
	output logic [VAL_W-1:0]        out_element,
	output logic                    out_last,
	output logic [COUNT_W-1:0]      out_count
);

	// ring slot of base plus offset
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
		input logic [IDX_W-1:0] offs);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, base} + {1'b0, offs};
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	logic [VAL_W-1:0]  mem_q [DEPTH];
	logic [VAL_W-1:0]  rd_data_q;
	logic [IDX_W-1:0]  front_q;
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  walk_q;

	logic              vld_q;
	status_t           status_q;
	logic [VAL_W-1:0]  element_q;
	logic              last_q;
	logic [COUNT_W-1:0] count_q;

	logic              full;
	logic              empty;
	logic [IDX_W-1:0]  front_dec;
	logic [IDX_W-1:0]  front_inc;
	logic [IDX_W-1:0]  back_slot;
	logic [IDX_W-1:0]  rd_addr;
	logic              walk_last;
	logic              out_free;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  front_d;
	logic [FILL_W-1:0] fill_d;
	status_t           status_d;

	// occupancy and ring slots
	assign full      = (fill_q == FILL_W'(DEPTH));
	assign empty     = (fill_q == '0);
	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
	assign front_inc = wrap_add(front_q, IDX_W'(1));
	assign back_slot = wrap_add(front_q, fill_q[IDX_W-1:0]);
	assign rd_addr   = wrap_add(front_q, walk_q);
	assign walk_last = ((FILL_W'(walk_q) + FILL_W'(1)) == fill_q);
	assign out_free  = !vld_q || out_ready;

	assign stat = '{
		req_dump:  (in_action == ACT_DUMP),
		empty:     empty,
		walk_last: walk_last,
		out_free:  out_free
	};

	// single-beat action decode
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = back_slot;
		front_d  = front_q;
		fill_d   = fill_q;
		status_d = ST_OK;
		unique case (act_t'(in_action))
			ACT_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = front_dec;
					front_d = front_dec;
					fill_d  = fill_q + FILL_W'(1);
				end
			end
			ACT_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en  = 1'b1;
					fill_d = fill_q + FILL_W'(1);
				end
			end
			ACT_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					fill_d = fill_q - FILL_W'(1);
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					front_d = front_inc;
					fill_d  = fill_q - FILL_W'(1);
				end
			end
			ACT_DUMP: begin
				status_d = ST_EMPTY;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// element store
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem_q[wr_addr] <= in_value;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// ring pointers and dump walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			fill_q  <= '0;
			walk_q  <= '0;
		end else begin
			if (cmd.exec) begin
				front_q <= front_d;
				fill_q  <= fill_d;
			end
			if (cmd.dump_start) begin
				walk_q <= '0;
			end else if (cmd.emit) begin
				walk_q <= walk_q + IDX_W'(1);
			end
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.exec || cmd.emit) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q  <= status_d;
			element_q <= '0;
			last_q    <= 1'b1;
			count_q   <= COUNT_W'(fill_d);
		end else if (cmd.emit) begin
			status_q  <= ST_OK;
			element_q <= rd_data_q;
			last_q    <= walk_last;
			count_q   <= COUNT_W'(fill_q);
		end
	end

	assign out_valid   = vld_q;
	assign out_status  = status_q;
	assign out_element = element_q;
	assign out_last    = last_q;
	assign out_count   = count_q;

endmodule

`default_nettype wire

// ===== design/bounded_deque_with_dump_top.sv =====
`default_nettype none

// Double-ended queue of up to 16 signed 32-bit values held in a ring buffer.
// Each input beat carries an action (push front, push back, pop back, pop
// front, dump) and a value; every result beat reports the status and the
// element count after the action. Pushes, pops, unused action codes and a
// dump of an empty queue each give one result beat, so such beats are
// accepted every cycle while the output is drained. A dump of n elements
// gives n result beats, front to back, the final one marked last, and holds
// off new input while it walks the store: each element takes a registered
// read of the store and then a load of the output register, which waits
// for the output to be free. The next input beat is taken once the last
// dump beat is in the output register. Store contents need no clearing
// after reset, so the block is ready as soon as reset is released.
module bounded_deque_with_dump_top import bdd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	bdd_in_if.sink   din,
	bdd_out_if.source dout
);

	ctl_cmd_t ctl_cmd;
	dp_stat_t dp_stat;

	bdd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.stat     (dp_stat),
		.cmd      (ctl_cmd)
	);

	bdd_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_action   (din.action),
		.in_value    (din.value),
		.cmd         (ctl_cmd),
		.stat        (dp_stat),
		.out_valid   (dout.valid),
		.out_ready   (dout.ready),
		.out_status  (dout.status),
		.out_element (dout.element),
		.out_last    (dout.last),
		.out_count   (dout.count)
	);

	// an accepted beat yields a result beat next cycle or starts a dump walk
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready) |=> (dout.valid || ctl_cmd.busy))
		else $error("accepted beat produced neither result nor dump walk");

	// no input is taken while a dump walk is in progress
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.busy |-> !din.ready)
		else $error("input accepted during dump walk");

	// count never exceeds the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.count <= COUNT_W'(DEPTH)))
		else $error("result count beyond depth");

	// an empty status always reports an empty queue on a final beat
	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.status == ST_EMPTY) |-> (dout.count == '0 && dout.last))
		else $error("empty status with nonzero count or not last");

endmodule

`default_nettype wire
